[sv/nfgb_pkg.sv]
// Shared types and constants for the neighbor force-gradient backprop block
`default_nettype none
package nfgb_pkg;

    localparam int VAL_W   = 32;
    localparam int PROD_W  = 2 * VAL_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int TOT_W   = PROD_W + 3;
    localparam int FRAC_W  = 16;
    localparam int CNT_W   = 9;
    localparam int ATOM_W  = 8;
    localparam int NB_W    = 9;

    localparam logic             CMD_LOAD          = 1'b0;
    localparam logic             CMD_PROCESS       = 1'b1;
    localparam logic [CNT_W-1:0] ATOM_COUNT_RESET  = 9'd256;

    typedef logic signed [VAL_W-1:0]  val_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic signed [TOT_W-1:0]  tot_t;

    typedef struct packed {
        val_t x;
        val_t y;
        val_t z;
    } vec3_t;

    typedef struct packed {
        logic valid;
        logic index_error;
    } stage_t;

endpackage
`default_nettype wire

[sv/nfgb_dot.sv]
// Dot-product pipeline: six products, partial sums, rounding and saturation
`default_nettype none
module nfgb_dot (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire nfgb_pkg::stage_t   src_info,
    input  wire nfgb_pkg::vec3_t    ctr_grad,
    input  wire nfgb_pkg::vec3_t    nb_grad,
    input  wire nfgb_pkg::vec3_t    deriv,
    output logic                    src_ready,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output nfgb_pkg::val_t          grad_value,
    output logic                    saturated,
    output logic                    index_error
);

    localparam int Q_W = nfgb_pkg::TOT_W - nfgb_pkg::FRAC_W;

    logic             b_valid_reg;
    logic             b_err_reg;
    nfgb_pkg::prod_t  b_pc_x_reg, b_pc_y_reg, b_pc_z_reg;
    nfgb_pkg::prod_t  b_pn_x_reg, b_pn_y_reg, b_pn_z_reg;

    logic             c_valid_reg;
    logic             c_err_reg;
    nfgb_pkg::sum_t   c_neg_reg;
    nfgb_pkg::sum_t   c_pos_reg;

    logic             out_valid_reg;
    nfgb_pkg::val_t   grad_reg;
    logic             sat_reg;
    logic             err_reg;

    logic             b_ready;
    logic             c_ready;
    logic             out_ready;

    nfgb_pkg::tot_t   total;
    logic signed [Q_W-1:0] q_val;
    logic             q_high;
    logic             q_low;
    nfgb_pkg::val_t   grad_next;
    logic             sat_next;

    assign out_ready = !out_valid_reg || !out_stall;
    assign c_ready   = !c_valid_reg || out_ready;
    assign b_ready   = !b_valid_reg || c_ready;
    assign src_ready = b_ready;

    // products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            b_valid_reg <= src_info.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && src_info.valid)
        begin
            b_err_reg  <= src_info.index_error;
            b_pc_x_reg <= ctr_grad.x * deriv.x;
            b_pc_y_reg <= ctr_grad.y * deriv.y;
            b_pc_z_reg <= ctr_grad.z * deriv.z;
            b_pn_x_reg <= nb_grad.x * deriv.x;
            b_pn_y_reg <= nb_grad.y * deriv.y;
            b_pn_z_reg <= nb_grad.z * deriv.z;
        end
    end

    // partial sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (c_ready)
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_ready && b_valid_reg)
        begin
            c_err_reg <= b_err_reg;
            c_neg_reg <= nfgb_pkg::SUM_W'(b_pc_x_reg) + nfgb_pkg::SUM_W'(b_pc_y_reg)
                         + nfgb_pkg::SUM_W'(b_pc_z_reg);
            c_pos_reg <= nfgb_pkg::SUM_W'(b_pn_x_reg) + nfgb_pkg::SUM_W'(b_pn_y_reg)
                         + nfgb_pkg::SUM_W'(b_pn_z_reg);
        end
    end

    // round half up, then clip to 32 bits
    always_comb
    begin
        total     = nfgb_pkg::TOT_W'(c_pos_reg) - nfgb_pkg::TOT_W'(c_neg_reg)
                    + nfgb_pkg::tot_t'(1 << (nfgb_pkg::FRAC_W - 1));
        q_val     = total[nfgb_pkg::TOT_W-1:nfgb_pkg::FRAC_W];
        q_high    = !q_val[Q_W-1] && (q_val[Q_W-2:nfgb_pkg::VAL_W-1] != '0);
        q_low     = q_val[Q_W-1] && (q_val[Q_W-2:nfgb_pkg::VAL_W-1] != '1);
        sat_next  = q_high || q_low;
        if (q_high)
        begin
            grad_next = {1'b0, {(nfgb_pkg::VAL_W-1){1'b1}}};
        end
        else if (q_low)
        begin
            grad_next = {1'b1, {(nfgb_pkg::VAL_W-1){1'b0}}};
        end
        else
        begin
            grad_next = q_val[nfgb_pkg::VAL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && c_valid_reg)
        begin
            grad_reg <= grad_next;
            sat_reg  <= sat_next;
            err_reg  <= c_err_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign grad_value  = grad_reg;
    assign saturated   = sat_reg;
    assign index_error = err_reg;

endmodule
`default_nettype wire

[sv/neighbor_force_gradient_backprop_top.sv]
// Top level: gradient store, neighbor checks and the dot-product pipeline
// A process item passes in order through the store read, product, partial-sum and output registers.
// Throughput: one item per cycle while in_stall is low; a load gives no result.
// The rate is set by the store's two read ports and one write port per cycle.
// Reset clears pipeline valids and sets atom_count to 256.
// Store contents are undefined until loaded; there is no clearing pass.
`default_nettype none
module neighbor_force_gradient_backprop_top #(
    parameter int MAX_ATOMS = 256
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write_en,
    input  wire logic [nfgb_pkg::CNT_W-1:0]         cfg_write_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               command,
    input  wire logic [nfgb_pkg::ATOM_W-1:0]        atom_index,
    input  wire logic signed [nfgb_pkg::NB_W-1:0]   neighbor_index,
    input  wire logic signed [nfgb_pkg::VAL_W-1:0]  value_x,
    input  wire logic signed [nfgb_pkg::VAL_W-1:0]  value_y,
    input  wire logic signed [nfgb_pkg::VAL_W-1:0]  value_z,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic signed [nfgb_pkg::VAL_W-1:0]       grad_value,
    output logic                                    saturated,
    output logic                                    index_error
);

    localparam int AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
    localparam int IW = (AW + 1 > nfgb_pkg::NB_W) ? AW + 1 : nfgb_pkg::NB_W;

    nfgb_pkg::vec3_t  grad_mem [MAX_ATOMS];

    logic [nfgb_pkg::CNT_W-1:0] atom_count_reg;

    logic             a_valid_reg;
    logic             a_ctr_ok_reg;
    logic             a_nb_ok_reg;
    logic             a_err_reg;
    nfgb_pkg::vec3_t  a_deriv_reg;
    nfgb_pkg::vec3_t  ctr_rd_reg;
    nfgb_pkg::vec3_t  nb_rd_reg;

    logic             a_ready;
    logic             dot_ready;
    logic             accept;
    logic             load_accept;
    logic             proc_accept;

    logic [IW-1:0]    ctr_ext;
    logic [IW-1:0]    nb_ext;
    logic [AW-1:0]    ctr_addr;
    logic [AW-1:0]    nb_addr;
    logic             ctr_in_store;
    logic             nb_none;
    logic             nb_err;
    logic             nb_ok;

    nfgb_pkg::vec3_t  in_vec;
    nfgb_pkg::vec3_t  ctr_grad;
    nfgb_pkg::vec3_t  nb_grad;
    nfgb_pkg::stage_t a_info;

    assign a_ready     = !a_valid_reg || dot_ready;
    assign in_stall    = !a_ready;
    assign accept      = in_valid && a_ready;

    assign ctr_ext      = IW'(atom_index);
    assign nb_ext       = IW'(neighbor_index[nfgb_pkg::NB_W-2:0]);
    assign ctr_addr     = ctr_ext[AW-1:0];
    assign nb_addr      = nb_ext[AW-1:0];
    assign ctr_in_store = ctr_ext < IW'(MAX_ATOMS);

    assign nb_none = neighbor_index[nfgb_pkg::NB_W-1]
                     || (neighbor_index[nfgb_pkg::NB_W-2:0] == atom_index);
    assign nb_err  = !nb_none
                     && ((nfgb_pkg::CNT_W'(neighbor_index[nfgb_pkg::NB_W-2:0]) >= atom_count_reg)
                         || (nb_ext >= IW'(MAX_ATOMS)));
    assign nb_ok   = !nb_none && !nb_err;

    assign load_accept = accept && (command == nfgb_pkg::CMD_LOAD) && ctr_in_store;
    assign proc_accept = accept && (command == nfgb_pkg::CMD_PROCESS);

    assign in_vec.x = value_x;
    assign in_vec.y = value_y;
    assign in_vec.z = value_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            atom_count_reg <= nfgb_pkg::ATOM_COUNT_RESET;
        end
        else if (cfg_write_en)
        begin
            atom_count_reg <= cfg_write_data;
        end
    end

    // store: one write port, two read ports
    always_ff @(posedge clk)
    begin
        if (load_accept)
        begin
            grad_mem[ctr_addr] <= in_vec;
        end
        if (proc_accept)
        begin
            ctr_rd_reg <= grad_mem[ctr_addr];
            nb_rd_reg  <= grad_mem[nb_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= proc_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_accept)
        begin
            a_ctr_ok_reg <= ctr_in_store;
            a_nb_ok_reg  <= nb_ok;
            a_err_reg    <= nb_err;
            a_deriv_reg  <= in_vec;
        end
    end

    // drop gradients that do not contribute
    assign ctr_grad = a_ctr_ok_reg ? ctr_rd_reg : '0;
    assign nb_grad  = a_nb_ok_reg ? nb_rd_reg : '0;

    assign a_info.valid       = a_valid_reg;
    assign a_info.index_error = a_err_reg;

    nfgb_dot u_dot (
        .clk         (clk),
        .rst_n       (rst_n),
        .src_info    (a_info),
        .ctr_grad    (ctr_grad),
        .nb_grad     (nb_grad),
        .deriv       (a_deriv_reg),
        .src_ready   (dot_ready),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .grad_value  (grad_value),
        .saturated   (saturated),
        .index_error (index_error)
    );

endmodule
`default_nettype wire
